// ----- hw/rtl/prime_count_in_range_assert.svh -----
// ----------------------------------------------------------------------------
// prime_count_in_range_assert.svh
// assertion macros shared by the prime range counter
// ----------------------------------------------------------------------------
`ifndef PRIME_COUNT_IN_RANGE_ASSERT_SVH
`define PRIME_COUNT_IN_RANGE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pcr assertion failed");

// next-cycle implication, checked outside reset
`define PCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pcr assertion failed");

`endif

// ----- hw/rtl/pcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcr_pkg
// types and constants of the segmented-sieve prime range counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcr_pkg;

  // field widths
  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 18;

  // controller states, one-hot
  typedef enum logic [15:0] {
    S_CLR   = 16'h0001,
    S_BRD   = 16'h0002,
    S_BCHK  = 16'h0004,
    S_BMARK = 16'h0008,
    S_CRD   = 16'h0010,
    S_CCHK  = 16'h0020,
    S_IDLE  = 16'h0040,
    S_CHK   = 16'h0080,
    S_PRD   = 16'h0100,
    S_PSQ   = 16'h0200,
    S_PCMP  = 16'h0400,
    S_DIV   = 16'h0800,
    S_MARK  = 16'h1000,
    S_CNT   = 16'h2000,
    S_CNTW  = 16'h4000,
    S_DONE  = 16'h8000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic i_init;
    logic i_inc;
    logic base_rd;
    logic j_load;
    logic base_mark;
    logic col_rd;
    logic col_step;
    logic in_load;
    logic set_err;
    logic tab_rd;
    logic sq_tab;
    logic div_start;
    logic m_load;
    logic mark_step;
    logic k_inc;
    logic cnt_init;
    logic cnt_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sq_ge_base;
    logic base_flag;
    logic j_ge_base;
    logic col_last;
    logic hi_lt_lo;
    logic too_long;
    logic k_end;
    logic pp_gt_hi;
    logic div_done;
    logic m_gt_hi;
    logic cnt_last;
  } sts_t;

endpackage

// ----- hw/rtl/pcr_div.sv -----
// ----------------------------------------------------------------------------
// pcr_div
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcr_div import pcr_pkg::*; #(
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVS_W-1:0] rem_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(IN_W);

  logic [IN_W-1:0]  dvd_q;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // shift in next dividend bit and trial subtract
  always_comb begin
    rem_sh  = {rem_q, dvd_q[IN_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_i};
    fits    = rem_sh >= {1'b0, divisor_i};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(IN_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[IN_W-2:0], 1'b0};
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/pcr_dp.sv -----
// ----------------------------------------------------------------------------
// pcr_dp
// datapath: base flag map, prime table, segment bitmap, counters, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcr_dp import pcr_pkg::*; #(
  parameter int unsigned BASE_LIMIT        = 65536,
  parameter int unsigned PRIME_TABLE_DEPTH = 8192,
  parameter int unsigned SEGMENT_SIZE      = 131072
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [2*IN_W-1:0] in_data_i,
  output logic [OUT_W-1:0]  out_count_o,
  output logic              out_err_o
);

  localparam int unsigned BASE_W = $clog2(BASE_LIMIT);
  localparam int unsigned SQ_W   = 2 * BASE_W;
  localparam int unsigned TAB_W  = $clog2(PRIME_TABLE_DEPTH);
  localparam int unsigned SEG_W  = $clog2(SEGMENT_SIZE);
  localparam int unsigned CNT_W  = SEG_W + 1;
  localparam int unsigned CLR_N  = (BASE_LIMIT > SEGMENT_SIZE) ? BASE_LIMIT : SEGMENT_SIZE;
  localparam int unsigned CLR_W  = $clog2(CLR_N);

  // memories
  logic              base_mem [BASE_LIMIT];
  logic [BASE_W-1:0] tab_mem  [PRIME_TABLE_DEPTH];
  logic              seg_mem  [SEGMENT_SIZE];

  logic [CLR_W-1:0]  clr_q;
  logic [BASE_W-1:0] i_q;
  logic [BASE_W:0]   j_q;
  logic [SQ_W-1:0]   sq_q;
  logic              base_rd_q;
  logic [BASE_W-1:0] tab_rd_q;
  logic [TAB_W:0]    total_q;
  logic [TAB_W:0]    k_q;
  logic [IN_W-1:0]   lo_q;
  logic [IN_W-1:0]   hi_q;
  logic [BASE_W-1:0] p_q;
  logic [IN_W:0]     m_q;
  logic [SEG_W-1:0]  idx_q;
  logic              seg_rd_q;
  logic              vld_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              err_q;
  logic [OUT_W-1:0]  out_cnt_q;
  logic              out_err_q;

  logic [BASE_W-1:0] mul_op;
  logic [IN_W-1:0]   lo_in;
  logic [IN_W-1:0]   diff;
  logic [IN_W-1:0]   ofs;
  logic [IN_W:0]     start0;
  logic [BASE_W-1:0] rem;
  logic              div_done;
  logic              clr_base;
  logic              clr_seg;
  logic              col_store;
  logic              seg_we;
  logic [SEG_W-1:0]  seg_wa;
  logic              seg_wd;

  // remainder of low bound by current prime
  pcr_div #(
    .DVS_W (BASE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (lo_q),
    .divisor_i  (p_q),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // combinational helpers
  always_comb begin
    mul_op    = cmd_i.sq_tab ? tab_rd_q : i_q;
    lo_in     = in_data_i[IN_W-1:0];
    diff      = hi_q - lo_q;
    ofs       = m_q[IN_W-1:0] - lo_q;
    start0    = (rem == '0) ? {1'b0, lo_q}
                            : {1'b0, lo_q} + (IN_W+1)'(p_q) - (IN_W+1)'(rem);
    clr_base  = cmd_i.clr_step && ({1'b0, clr_q} < (CLR_W+1)'(BASE_LIMIT));
    clr_seg   = cmd_i.clr_step && ({1'b0, clr_q} < (CLR_W+1)'(SEGMENT_SIZE));
    col_store = cmd_i.col_step && !base_rd_q
                && (total_q < (TAB_W+1)'(PRIME_TABLE_DEPTH));
  end

  // segment write port select
  always_comb begin
    seg_we = 1'b0;
    seg_wa = idx_q;
    seg_wd = 1'b0;
    if (clr_seg) begin
      seg_we = 1'b1;
      seg_wa = clr_q[SEG_W-1:0];
    end else if (cmd_i.mark_step) begin
      seg_we = 1'b1;
      seg_wa = ofs[SEG_W-1:0];
      seg_wd = 1'b1;
    end else if (cmd_i.cnt_step) begin
      seg_we = 1'b1;
    end
  end

  // base flag map
  always_ff @(posedge clk_i) begin
    if (clr_base) begin
      base_mem[clr_q[BASE_W-1:0]] <= 1'b0;
    end else if (cmd_i.base_mark) begin
      base_mem[j_q[BASE_W-1:0]] <= 1'b1;
    end
    if (cmd_i.base_rd || cmd_i.col_rd) begin
      base_rd_q <= base_mem[i_q];
    end
  end

  // prime table
  always_ff @(posedge clk_i) begin
    if (col_store) begin
      tab_mem[total_q[TAB_W-1:0]] <= i_q;
    end
    if (cmd_i.tab_rd) begin
      tab_rd_q <= tab_mem[k_q[TAB_W-1:0]];
    end
  end

  // segment bitmap, read-first so counting also clears
  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    if (cmd_i.cnt_step) begin
      seg_rd_q <= seg_mem[idx_q];
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      total_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= cmd_i.cnt_step;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (col_store) begin
        total_q <= total_q + 1'b1;
      end
    end
  end

  // base sieve indices and squares
  always_ff @(posedge clk_i) begin
    if (cmd_i.i_init) begin
      i_q <= BASE_W'(2);
    end else if (cmd_i.i_inc || cmd_i.col_step) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.base_rd || cmd_i.sq_tab) begin
      sq_q <= SQ_W'(mul_op) * SQ_W'(mul_op);
    end
    if (cmd_i.j_load) begin
      j_q <= sq_q[BASE_W:0];
    end else if (cmd_i.base_mark) begin
      j_q <= j_q + (BASE_W+1)'(i_q);
    end
  end

  // query registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      lo_q  <= (lo_in < IN_W'(2)) ? IN_W'(2) : lo_in;
      hi_q  <= in_data_i[2*IN_W-1:IN_W];
      k_q   <= '0;
      err_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.cnt_init) begin
        cnt_q <= '0;
      end else if (vld_q && !seg_rd_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
    if (cmd_i.sq_tab) begin
      p_q <= tab_rd_q;
    end
    if (cmd_i.m_load) begin
      m_q <= (start0 > (IN_W+1)'(sq_q)) ? start0 : (IN_W+1)'(sq_q);
    end else if (cmd_i.mark_step) begin
      m_q <= m_q + (IN_W+1)'(p_q);
    end
    if (cmd_i.cnt_init) begin
      idx_q <= '0;
    end else if (cmd_i.cnt_step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cnt_q <= OUT_W'(cnt_q);
      out_err_q <= err_q;
    end
  end

  // status
  always_comb begin
    sts_o.clr_last   = clr_q == CLR_W'(CLR_N - 1);
    sts_o.sq_ge_base = sq_q >= SQ_W'(BASE_LIMIT);
    sts_o.base_flag  = base_rd_q;
    sts_o.j_ge_base  = j_q >= (BASE_W+1)'(BASE_LIMIT);
    sts_o.col_last   = i_q == BASE_W'(BASE_LIMIT - 1);
    sts_o.hi_lt_lo   = hi_q < lo_q;
    sts_o.too_long   = diff >= IN_W'(SEGMENT_SIZE);
    sts_o.k_end      = k_q == total_q;
    sts_o.pp_gt_hi   = IN_W'(sq_q) > hi_q;
    sts_o.div_done   = div_done;
    sts_o.m_gt_hi    = m_q > {1'b0, hi_q};
    sts_o.cnt_last   = idx_q == diff[SEG_W-1:0];
  end

  assign out_count_o = out_cnt_q;
  assign out_err_o   = out_err_q;

endmodule

// ----- hw/rtl/pcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcr_ctrl
// sequencer for base sieve, per-item segment sieve and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcr_ctrl import pcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.i_init = 1'b1;
          state_d      = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.base_rd = 1'b1;
        state_d       = S_BCHK;
      end
      S_BCHK: begin
        if (sts_i.sq_ge_base) begin
          cmd_o.i_init = 1'b1;
          state_d      = S_CRD;
        end else if (sts_i.base_flag) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_BRD;
        end else begin
          cmd_o.j_load = 1'b1;
          state_d      = S_BMARK;
        end
      end
      S_BMARK: begin
        if (sts_i.j_ge_base) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_BRD;
        end else begin
          cmd_o.base_mark = 1'b1;
        end
      end
      S_CRD: begin
        cmd_o.col_rd = 1'b1;
        state_d      = S_CCHK;
      end
      S_CCHK: begin
        cmd_o.col_step = 1'b1;
        state_d        = sts_i.col_last ? S_IDLE : S_CRD;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.hi_lt_lo) begin
          state_d = S_DONE;
        end else if (sts_i.too_long) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        if (sts_i.k_end) begin
          cmd_o.cnt_init = 1'b1;
          state_d        = S_CNT;
        end else begin
          cmd_o.tab_rd = 1'b1;
          state_d      = S_PSQ;
        end
      end
      S_PSQ: begin
        cmd_o.sq_tab = 1'b1;
        state_d      = S_PCMP;
      end
      S_PCMP: begin
        if (sts_i.pp_gt_hi) begin
          cmd_o.cnt_init = 1'b1;
          state_d        = S_CNT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.m_load = 1'b1;
          state_d      = S_MARK;
        end
      end
      S_MARK: begin
        if (sts_i.m_gt_hi) begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_PRD;
        end else begin
          cmd_o.mark_step = 1'b1;
        end
      end
      S_CNT: begin
        cmd_o.cnt_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_CNTW;
        end
      end
      S_CNTW: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/prime_count_in_range.sv -----
// ----------------------------------------------------------------------------
// prime_count_in_range
// counts the primes in a closed range with a segmented sieve
// ----------------------------------------------------------------------------
// Input stream: one item per range, tdata holds range_low and range_high.
// Output stream: one item per range, prime_count in tdata, range_error in tuser.
// After reset the block is busy with a clearing pass over the base flag map and
// the segment bitmap, then runs the base sieve, which marks the multiples of
// each base prime and fills the prime table. s_axis_tready stays low until that
// is done.
// Per item: an empty or too-long range goes from the range check straight to
// the result register. Otherwise each base prime p with p*p <= high takes a
// table read, a square and a pass of the bit-serial remainder unit, then marks
// its multiples in the segment; after the last prime the count pass reads and
// clears the segment at one bit per cycle. The single-port segment bitmap and
// the bit-serial remainder unit set the time an item takes.
// One item is worked on at a time. The result sits in an output register, so
// a stalled receiver does not stop the next item from being accepted and
// sieved; only handing over its result waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prime_count_in_range_assert.svh"

module prime_count_in_range import pcr_pkg::*; #(
  parameter int unsigned BASE_LIMIT        = 65536,
  parameter int unsigned PRIME_TABLE_DEPTH = 8192,
  parameter int unsigned SEGMENT_SIZE      = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] range_low, [63:32] range_high
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] prime_count, [23:18] zero
  output logic        m_axis_tuser    // [0] range_error
);

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] out_count;

  pcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  pcr_dp #(
    .BASE_LIMIT        (BASE_LIMIT),
    .PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH),
    .SEGMENT_SIZE      (SEGMENT_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_count_o (out_count),
    .out_err_o   (m_axis_tuser)
  );

  // output packing
  assign m_axis_tdata = {6'b0, out_count};

  // checks
  `PCR_ASSERT_IMP(a_mark_in_range, clk_i, rst_ni, cmd.mark_step, !sts.m_gt_hi)
  `PCR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PCR_ASSERT_IMP(a_error_zero_count, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, out_count == '0)

endmodule

// ----- bench/prime_count_in_range_checker.sv -----
// ----------------------------------------------------------------------------
// prime_count_in_range_checker
// watches both streams, predicts each count and compares it on arrival
// ----------------------------------------------------------------------------
// Keeps its own base sieve of all primes below BASE_LIMIT and, for every range
// item taken by the block, sieves the range in a local bitmap to get the
// expected count and error flag. Expected results wait in order in a queue and
// each result item from the block is checked against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_count_in_range_checker import pcr_pkg::*; #(
  parameter int unsigned BASE_LIMIT        = 65536,
  parameter int unsigned PRIME_TABLE_DEPTH = 8192,
  parameter int unsigned SEGMENT_SIZE      = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [63:0] s_data_i,     // [31:0] range_low, [63:32] range_high
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [23:0] m_data_i,     // [17:0] prime_count, [23:18] zero
  input  logic        m_user_i,     // [0] range_error
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          accepted_o,
  output int          too_long_o
);

  typedef struct packed {
    logic [OUT_W-1:0] prime_count;
    logic             range_error;
  } range_result_t;

  // local sieve state
  bit              composite_map [BASE_LIMIT];
  longint unsigned sieve_primes  [PRIME_TABLE_DEPTH];
  int unsigned     sieve_prime_cnt;
  bit              window_mark   [SEGMENT_SIZE];

  range_result_t   expected_counts [$];

  // base sieve, done once before any range arrives
  initial begin
    int unsigned i;
    int unsigned j;
    for (i = 0; i < BASE_LIMIT; i++) composite_map[i] = 1'b0;
    composite_map[0] = 1'b1;
    composite_map[1] = 1'b1;
    for (i = 2; i * i < BASE_LIMIT; i++) begin
      if (!composite_map[i]) begin
        for (j = i * i; j < BASE_LIMIT; j += i) composite_map[j] = 1'b1;
      end
    end
    sieve_prime_cnt = 0;
    for (i = 2; i < BASE_LIMIT; i++) begin
      if (!composite_map[i] && sieve_prime_cnt < PRIME_TABLE_DEPTH) begin
        sieve_primes[sieve_prime_cnt] = i;
        sieve_prime_cnt++;
      end
    end
  end

  // segmented sieve of one closed range
  function automatic range_result_t count_primes_in_range(input logic [IN_W-1:0] lo_arg,
                                                          input logic [IN_W-1:0] hi_arg);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    longint unsigned p;
    longint unsigned m;
    longint unsigned idx;
    int unsigned     k;
    int unsigned     tally;
    range_result_t   res;
    lo  = lo_arg;
    hi  = hi_arg;
    res = '0;
    // a low bound of 0 or 1 starts at 2
    if (lo < 2) lo = 2;
    if (hi < lo) begin
      // empty range: zero count and no error
      res = '0;
    end else if (hi - lo + 1 > SEGMENT_SIZE) begin
      res.range_error = 1'b1;
    end else begin
      span = hi - lo + 1;
      for (idx = 0; idx < span; idx++) window_mark[idx] = 1'b0;
      for (k = 0; k < sieve_prime_cnt && sieve_primes[k] * sieve_primes[k] <= hi; k++) begin
        p = sieve_primes[k];
        // first multiple at or above lo, never below p*p so p itself stays
        m = (lo + p - 1) / p * p;
        if (m < p * p) m = p * p;
        while (m <= hi) begin
          window_mark[m - lo] = 1'b1;
          m += p;
        end
      end
      tally = 0;
      for (idx = 0; idx < span; idx++) begin
        if (!window_mark[idx]) tally++;
      end
      res.prime_count = tally[OUT_W-1:0];
    end
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    accepted_o   = 0;
    too_long_o   = 0;
  end

  // predict on input items, compare on output items
  always @(posedge clk_i) begin
    range_result_t want;
    if (rst_ni) begin
      if (s_valid_i && s_ready_i) begin
        want = count_primes_in_range(s_data_i[31:0], s_data_i[63:32]);
        expected_counts.insert(expected_counts.size(), want);
        accepted_o++;
        if (want.range_error) too_long_o++;
      end
      if (m_valid_i && m_ready_i) begin
        if (expected_counts.size() == 0) begin
          $error("result item with no range waiting: prime_count %0d range_error %0b",
                 m_data_i[OUT_W-1:0], m_user_i);
          fail_count_o++;
        end else begin
          want = expected_counts.pop_front();
          checked_o++;
          if (m_data_i[OUT_W-1:0] !== want.prime_count) begin
            $error("prime_count mismatch: expected %0d, actual %0d",
                   want.prime_count, m_data_i[OUT_W-1:0]);
            fail_count_o++;
          end
          if (m_user_i !== want.range_error) begin
            $error("range_error mismatch: expected %0b, actual %0b",
                   want.range_error, m_user_i);
            fail_count_o++;
          end
          if (m_data_i[23:OUT_W] !== '0) begin
            $error("tdata padding mismatch: expected 0, actual %0h", m_data_i[23:OUT_W]);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

// ----- bench/prime_count_in_range_tb.sv -----
// ----------------------------------------------------------------------------
// prime_count_in_range_tb
// stream-level test of the segmented-sieve prime range counter
// ----------------------------------------------------------------------------
// Sends range items through the input stream: a directed set around the low
// bound adjustment, empty ranges, the segment length boundary and the top of
// the 32-bit space, then random ranges, mostly short ones that get sieved,
// the rest empty or too long. Sender and receiver idle at random in three
// mixes, and the receiver holds off once for a long stretch so the block backs
// up. The checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_count_in_range_tb import pcr_pkg::*; ();

  localparam int unsigned BASE_LIMIT        = 65536;
  localparam int unsigned PRIME_TABLE_DEPTH = 8192;
  localparam int unsigned SEGMENT_SIZE      = 131072;
  localparam int unsigned N_RANDOM          = 100;
  localparam int unsigned HOLD_CYCLES       = 30000;
  localparam int unsigned DRAIN_CYCLES      = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // [31:0] range_low, [63:32] range_high
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;    // [17:0] prime_count, [23:18] zero
  logic        m_axis_tuser;    // [0] range_error

  int   src_idle_pct;
  int   dst_idle_pct;
  logic hold_req;

  int   fail_count;
  int   pending;
  int   checked;
  int   accepted;
  int   too_long;

  prime_count_in_range #(
    .BASE_LIMIT        (BASE_LIMIT),
    .PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH),
    .SEGMENT_SIZE      (SEGMENT_SIZE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  prime_count_in_range_checker #(
    .BASE_LIMIT        (BASE_LIMIT),
    .PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH),
    .SEGMENT_SIZE      (SEGMENT_SIZE)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .accepted_o   (accepted),
    .too_long_o   (too_long)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, well past the slowest correct run including the startup sieve
  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random idling, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  // offer one range item, called and returning at a falling edge
  task automatic push_range(input logic [IN_W-1:0] lo, input logic [IN_W-1:0] hi);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    logic [IN_W-1:0] lo;
    logic [IN_W-1:0] hi;
    int unsigned     bits;
    int unsigned     span;
    int unsigned     sel;
    int unsigned     r;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    src_idle_pct  = 34;
    dst_idle_pct  = 55;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // low bound below two and empty ranges
    push_range(32'd0, 32'd0);
    push_range(32'd1, 32'd1);
    push_range(32'd1, 32'd2);
    push_range(32'd0, 32'd10);
    push_range(32'd10, 32'd5);
    push_range(32'hFFFF_FFFF, 32'd0);
    // single numbers: smallest prime, a square, a prime as its own low bound
    push_range(32'd2, 32'd2);
    push_range(32'd4, 32'd4);
    push_range(32'd49, 32'd49);
    push_range(32'd3, 32'd3);
    push_range(32'd97, 32'd97);
    // around the base sieve limit and a mid-size window
    push_range(32'd65521, 32'd65537);
    push_range(32'd1000000, 32'd1000100);
    // segment length boundary, exactly full only after the low bound moves to 2
    push_range(32'd1, 32'd131073);
    push_range(32'd2, 32'd131074);
    push_range(32'd0, 32'hFFFF_FFFF);
    // top of the 32-bit space, every base prime takes part
    push_range(32'hFFFF_FFFB, 32'hFFFF_FFFF);

    for (r = 0; r < N_RANDOM; r++) begin
      if (r == N_RANDOM / 3) begin
        src_idle_pct = 55;
        dst_idle_pct <= 34;
      end
      if (r == 2 * N_RANDOM / 3) begin
        src_idle_pct = 0;
        dst_idle_pct <= 0;
        hold_req     <= 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // short range at a small base
        bits = $urandom_range(2, 16);
        lo   = $urandom & ((32'd1 << bits) - 32'd1);
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 64);
        hi   = lo + span - 1;
      end else if (sel < 75) begin
        // short range further up
        lo = $urandom_range(32'd1 << 22, 0);
        hi = lo + $urandom_range(63, 0);
      end else if (sel < 88) begin
        // empty range over the full field width
        hi = $urandom_range(32'hFFFF_FFFE, 0);
        lo = $urandom_range(32'hFFFF_FFFF, hi + 32'd1);
      end else begin
        // range longer than the segment store
        lo = $urandom_range(32'hFFFD_FFFF, 2);
        hi = $urandom_range(32'hFFFF_FFFF, lo + SEGMENT_SIZE);
      end
      push_range(lo, hi);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("ranges accepted: %0d, %0d of them over the segment size; results checked: %0d",
             accepted, too_long, checked);
    $display("idle mixes: sender 34/receiver 55, swapped, none; one %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_div.sv
hw/rtl/pcr_dp.sv
hw/rtl/pcr_ctrl.sv
hw/rtl/prime_count_in_range.sv
bench/prime_count_in_range_checker.sv
bench/prime_count_in_range_tb.sv
